// ===== rtl/current_sense_dc_rms_averager_defines.svh =====
// Assertion macros shared by the averager RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef CURRENT_SENSE_DC_RMS_AVERAGER_DEFINES_SVH
`define CURRENT_SENSE_DC_RMS_AVERAGER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CSA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);
`define CSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define CSA_ASSERT(label, prop, msg)
`define CSA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/csa_pkg.sv =====
package csa_pkg;

	// Port and field widths
	localparam int SAMPLE_W   = 12;
	localparam int VALUE_W    = 24;
	localparam int MODE_W     = 2;
	localparam int CNT_W      = 10;
	localparam int ZP_W       = 16;
	localparam int GAIN_W     = 24;
	localparam int SUM_W      = 48;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;

	// Shared arithmetic unit widths
	localparam int NUM_W      = 53;  // division numerator / quotient
	localparam int ALU_W      = 49;  // add/subtract width, also product width
	localparam int ROOT_W     = 25;  // square root result, multiplier operand
	localparam int RAD_W      = 50;  // radicand padded to an even bit count
	localparam int SQ_REM_W   = 29;  // root remainder slice with two new bits
	localparam int SQ_W       = 32;  // squared offset
	localparam int STEP_W     = 6;
	localparam int MAG_SHIFT  = 18;
	localparam int MAG_W      = ALU_W - MAG_SHIFT;

	localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(NUM_W);
	localparam logic [STEP_W-1:0] ROOT_STEPS = STEP_W'(ROOT_W);
	localparam logic [STEP_W-1:0] MUL_STEPS  = STEP_W'(ROOT_W);

	localparam logic [ALU_W-1:0] ROUND_BIAS = ALU_W'(64'd1 << (MAG_SHIFT - 1));
	localparam logic [MAG_W-1:0] OUT_POS_LIM = MAG_W'(64'd8388607);
	localparam logic [MAG_W-1:0] OUT_NEG_LIM = MAG_W'(64'd8388608);
	localparam logic [ZP_W-1:0]  MEAN_MAX    = '1;

	// Mode codes
	localparam logic [MODE_W-1:0] MODE_DC     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RMS    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CAL    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_DC_ALT = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE       = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 8'd3;

	// Register reset values
	localparam logic [MODE_W-1:0] RST_MODE       = MODE_DC;
	localparam logic [CNT_W-1:0]  RST_WINDOW_LEN = 10'd100;
	localparam logic [ZP_W-1:0]   RST_ZERO_POINT = 16'd32768;
	localparam logic [GAIN_W-1:0] RST_GAIN       = 24'd432392;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} csa_op_t;

	typedef struct packed {
		logic    start;
		csa_op_t op;
		logic    bias;
	} csa_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} csa_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQR,
		ST_SQW,
		ST_ACC,
		ST_DIV,
		ST_DIVW,
		ST_SQRTW,
		ST_MULW,
		ST_OUT
	} csa_state_t;

endpackage

// ===== rtl/current_sense_dc_rms_averager.sv =====
// Channel   Dir  Signals                                   Beat
// cfg       in   cfg_valid/cfg_ready cfg_index cfg_data     one register write
// in        in   in_valid/in_ready   sample                 one ADC sample
// out       out  out_valid/out_ready value saturated        one window result
//
// In dc and calibrate a sample that leaves its window open is simply added to the
// window; in rms 25 multiply steps first square its offset. A sample that closes a
// window then runs a divide, followed by a multiply in dc and a root and a multiply in rms;
// one shared add/subtract unit runs 53 divide, 25 root and 25 multiply steps.
// Reset clears the window and loads the register defaults; no clearing pass.
// A result waits in the output register; the next window end holds until it leaves.
`include "current_sense_dc_rms_averager_defines.svh"

module current_sense_dc_rms_averager import csa_pkg::*; #(
	parameter int ADC_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [SAMPLE_W-1:0]        sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [VALUE_W-1:0]  value,
	output logic                       saturated
);

	localparam int SBITS = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << SBITS) - 64'd1);

	csa_state_t           state_q;
	csa_state_t           state_d;

	logic [MODE_W-1:0]    mode_q;
	logic [CNT_W-1:0]     window_len_q;
	logic [ZP_W-1:0]      zero_point_q;
	logic [GAIN_W-1:0]    gain_q;
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SAMPLE_W-1:0]  samp_q;
	logic                 sat_q;
	logic                 neg_q;
	logic [VALUE_W-1:0]   val_q;
	logic                 out_valid_q;
	logic [VALUE_W-1:0]   value_q;
	logic                 sat_out_q;

	csa_req_t             req;
	csa_rsp_t             rsp;
	logic [NUM_W-1:0]     opa;
	logic [GAIN_W-1:0]    opb;
	logic [NUM_W-1:0]     result;

	logic                 is_rms;
	logic                 is_cal;
	logic [CNT_W-1:0]     n_w;
	logic [CNT_W-1:0]     half_n;
	logic [ZP_W-1:0]      sq4;
	logic [ZP_W-1:0]      d_mag;
	logic [CNT_W-1:0]     cnt_inc;
	logic                 win_end;
	logic [SUM_W-1:0]     addend;
	logic [NUM_W-1:0]     numer;
	logic                 mean_sat;
	logic [ZP_W-1:0]      mean;
	logic                 mean_below;
	logic [ZP_W-1:0]      diff_mag;
	logic [MAG_W-1:0]     mag;
	logic [MAG_W-1:0]     lim;
	logic                 clip;
	logic [MAG_W-1:0]     mag_c;
	logic [VALUE_W-1:0]   mag24;
	logic [VALUE_W-1:0]   val_signed;
	logic                 accept;
	logic                 out_free;
	logic                 load_out;

	// Decode the mode; the spare code runs as dc
	always_comb begin
		is_rms = 1'b0;
		is_cal = 1'b0;
		case (mode_q) inside
			MODE_RMS:             is_rms = 1'b1;
			MODE_CAL:             is_cal = 1'b1;
			MODE_DC, MODE_DC_ALT: is_rms = 1'b0;
			default:              is_rms = 1'b0;
		endcase
	end

	// Window length and end of window
	assign n_w     = (window_len_q == '0) ? CNT_W'(1) : window_len_q;
	assign half_n  = n_w >> 1;
	assign cnt_inc = cnt_q + CNT_W'(1);
	assign win_end = (cnt_inc >= n_w) || (cnt_inc == '0);

	// Offset of the sample from the zero point, Q4 counts
	assign sq4   = {samp_q, 4'b0000};
	assign d_mag = (sq4 >= zero_point_q) ? (sq4 - zero_point_q) : (zero_point_q - sq4);

	assign addend = is_rms ? SUM_W'(result[SQ_W-1:0]) : SUM_W'(samp_q);
	assign numer  = is_rms ? (NUM_W'(sum_q) + NUM_W'(half_n))
	                       : (NUM_W'({sum_q, 4'b0000}) + NUM_W'(half_n));

	// Window mean, clipped to 16 bits
	assign mean_sat   = |result[NUM_W-1:ZP_W];
	assign mean       = mean_sat ? MEAN_MAX : result[ZP_W-1:0];
	assign mean_below = mean < zero_point_q;
	assign diff_mag   = mean_below ? (zero_point_q - mean) : (mean - zero_point_q);

	// Scaled magnitude, clip and sign
	assign mag        = result[ALU_W-1:MAG_SHIFT];
	assign lim        = neg_q ? OUT_NEG_LIM : OUT_POS_LIM;
	assign clip       = mag > lim;
	assign mag_c      = clip ? lim : mag;
	assign mag24      = mag_c[VALUE_W-1:0];
	assign val_signed = neg_q ? VALUE_W'(~mag24 + VALUE_W'(1)) : mag24;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign load_out = (state_q == ST_OUT) && out_free;

	// Sequencer: next state and unit requests
	always_comb begin
		state_d   = state_q;
		req       = '0;
		opa       = '0;
		opb       = '0;
		in_ready  = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = is_rms ? ST_SQR : ST_ACC;
				end
			end
			ST_SQR: begin
				req.start = 1'b1;
				req.op    = OP_MUL;
				opa       = NUM_W'(d_mag);
				opb       = GAIN_W'(d_mag);
				state_d   = ST_SQW;
			end
			ST_SQW: begin
				if (rsp.done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				state_d = win_end ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				req.start = 1'b1;
				req.op    = OP_DIV;
				opa       = numer;
				opb       = GAIN_W'(n_w);
				state_d   = ST_DIVW;
			end
			ST_DIVW: begin
				if (rsp.done) begin
					if (is_rms) begin
						req.start = 1'b1;
						req.op    = OP_SQRT;
						opa       = NUM_W'(result[ALU_W-1:0]);
						state_d   = ST_SQRTW;
					end else if (is_cal) begin
						state_d = ST_OUT;
					end else begin
						req.start = 1'b1;
						req.op    = OP_MUL;
						req.bias  = 1'b1;
						opa       = NUM_W'(diff_mag);
						opb       = gain_q;
						state_d   = ST_MULW;
					end
				end
			end
			ST_SQRTW: begin
				if (rsp.done) begin
					req.start = 1'b1;
					req.op    = OP_MUL;
					req.bias  = 1'b1;
					opa       = result;
					opb       = gain_q;
					state_d   = ST_MULW;
				end
			end
			ST_MULW: begin
				if (rsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Registers, window accumulator and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= RST_MODE;
			window_len_q <= RST_WINDOW_LEN;
			zero_point_q <= RST_ZERO_POINT;
			gain_q       <= RST_GAIN;
			sum_q        <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MODE:       mode_q       <= cfg_data[MODE_W-1:0];
					REG_WINDOW_LEN: window_len_q <= cfg_data[CNT_W-1:0];
					REG_ZERO_POINT: zero_point_q <= cfg_data[ZP_W-1:0];
					REG_GAIN:       gain_q       <= cfg_data[GAIN_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == ST_ACC) begin
				sum_q <= sum_q + addend;
				cnt_q <= win_end ? '0 : cnt_inc;
			end
			if (state_q == ST_DIV) begin
				sum_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: hold the sample, build the result, load the output stage
	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q <= sample & SAMPLE_MASK;
		end
		if (state_q == ST_DIVW && rsp.done && !is_rms) begin
			sat_q <= mean_sat;
			neg_q <= mean_below;
			val_q <= VALUE_W'(mean);
		end
		if (state_q == ST_SQRTW && rsp.done) begin
			sat_q <= 1'b0;
			neg_q <= 1'b0;
		end
		if (state_q == ST_MULW && rsp.done) begin
			val_q <= val_signed;
			sat_q <= sat_q | clip;
		end
		if (load_out) begin
			value_q   <= val_q;
			sat_out_q <= sat_q;
		end
	end

	csa_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (opa),
		.opb    (opb),
		.rsp    (rsp),
		.result (result)
	);

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign saturated = sat_out_q;

	`CSA_ASSERT(a_out_from_emit, $rose(out_valid_q) |-> $past(state_q == ST_OUT), "result appeared outside emit")
	`CSA_ASSERT(a_window_cleared, $rose(out_valid_q) |-> (cnt_q == '0 && sum_q == '0), "window not cleared after result")
	`CSA_ASSERT(a_cal_clip, (out_valid_q && sat_out_q && is_cal) |-> (value_q == VALUE_W'(MEAN_MAX)), "clipped calibrate mean wrong")
	`CSA_ASSERT(a_wait_busy, (state_q == ST_MULW && !rsp.done) |-> rsp.busy, "waiting on an idle unit")

endmodule

// ===== rtl/csa_unit.sv =====
`include "current_sense_dc_rms_averager_defines.svh"

module csa_unit import csa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  csa_req_t          req,
	input  logic [NUM_W-1:0]  opa,
	input  logic [GAIN_W-1:0] opb,
	output csa_rsp_t          rsp,
	output logic [NUM_W-1:0]  result
);

	logic                busy_q;
	logic                done_q;
	csa_op_t             op_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [STEP_W-1:0]   load_steps;
	logic [ALU_W-1:0]    acc_q;
	logic [NUM_W-1:0]    wrk_q;
	logic [ALU_W-1:0]    aux_q;
	logic                load;

	logic [ALU_W-1:0]    alu_x;
	logic [ALU_W-1:0]    alu_y;
	logic                alu_sub;
	logic [ALU_W-1:0]    alu_sum;
	logic                alu_co;

	logic [ROOT_W-1:0]   root;
	logic                round_up;
	logic [ROOT_W-1:0]   root_rnd;

	assign load = req.start && !busy_q;

	// Step count per operation
	always_comb begin
		unique case (req.op)
			OP_DIV:  load_steps = DIV_STEPS;
			OP_SQRT: load_steps = ROOT_STEPS;
			default: load_steps = MUL_STEPS;
		endcase
	end

	// Shared add/subtract: operands chosen by the running operation
	always_comb begin
		alu_x   = '0;
		alu_y   = '0;
		alu_sub = 1'b0;
		unique case (op_q)
			OP_MUL: begin
				alu_x = acc_q;
				alu_y = aux_q;
			end
			OP_DIV: begin
				alu_x   = ALU_W'({acc_q[CNT_W-1:0], wrk_q[NUM_W-1]});
				alu_y   = ALU_W'(aux_q[CNT_W-1:0]);
				alu_sub = 1'b1;
			end
			OP_SQRT: begin
				alu_x   = ALU_W'({acc_q[SQ_REM_W-3:0], wrk_q[RAD_W-1 -: 2]});
				alu_y   = ALU_W'({aux_q[ROOT_W-1:0], 2'b01});
				alu_sub = 1'b1;
			end
			default: begin
				alu_x = '0;
			end
		endcase
		{alu_co, alu_sum} = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
			+ (ALU_W + 1)'(alu_sub);
	end

	// Sequencer: load, count steps, flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= load_steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Working registers: one multiply, divide or root step per cycle
	always_ff @(posedge clk) begin
		if (load) begin
			unique case (req.op)
				OP_DIV: begin
					acc_q <= '0;
					wrk_q <= opa;
					aux_q <= ALU_W'(opb[CNT_W-1:0]);
				end
				OP_SQRT: begin
					acc_q <= '0;
					wrk_q <= opa;
					aux_q <= '0;
				end
				default: begin
					acc_q <= req.bias ? ROUND_BIAS : '0;
					wrk_q <= opa;
					aux_q <= ALU_W'(opb);
				end
			endcase
		end else if (busy_q) begin
			unique case (op_q)
				OP_DIV: begin
					acc_q <= alu_co ? alu_sum : alu_x;
					wrk_q <= {wrk_q[NUM_W-2:0], alu_co};
				end
				OP_SQRT: begin
					acc_q <= alu_co ? alu_sum : alu_x;
					aux_q <= {aux_q[ALU_W-2:0], alu_co};
					wrk_q <= {wrk_q[NUM_W-3:0], 2'b00};
				end
				default: begin
					if (wrk_q[0]) begin
						acc_q <= alu_sum;
					end
					wrk_q <= {1'b0, wrk_q[NUM_W-1:1]};
					aux_q <= {aux_q[ALU_W-2:0], 1'b0};
				end
			endcase
		end
	end

	// Round the root up when the remainder exceeds it
	assign root     = aux_q[ROOT_W-1:0];
	assign round_up = acc_q > ALU_W'(root);
	assign root_rnd = root + ROOT_W'(round_up);

	always_comb begin
		unique case (op_q)
			OP_DIV:  result = wrk_q;
			OP_SQRT: result = NUM_W'(root_rnd);
			default: result = NUM_W'(acc_q);
		endcase
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;

	`CSA_ASSERT(a_start_idle, req.start |-> !busy_q, "unit started while busy")
	`CSA_ASSERT_NEXT(a_start_busy, req.start, busy_q, "unit did not go busy on start")
	`CSA_ASSERT(a_div_rem, (done_q && op_q == OP_DIV) |-> (acc_q[CNT_W-1:0] < aux_q[CNT_W-1:0]), "division remainder not below divisor")
	`CSA_ASSERT(a_root_rem, (done_q && op_q == OP_SQRT) |-> (acc_q <= (aux_q << 1)), "root remainder out of range")

endmodule

// ===== sim/tb_current_sense_dc_rms_averager.sv =====
`timescale 1ns / 100ps

module tb_current_sense_dc_rms_averager import csa_pkg::*;;

	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned SETTLE_CYCLES = 200;
	localparam int unsigned RANDOM_ITEMS  = 470;

	localparam logic [CFG_IDX_W-1:0] REG_NONE   = 8'hFF;
	localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX = '1;
	localparam logic [GAIN_W-1:0]    GAIN_MAX   = '1;

	localparam logic [63:0] POS_LIMIT = 64'd8388607;
	localparam logic [63:0] NEG_LIMIT = 64'd8388608;
	localparam logic [63:0] MEAN_CLIP = 64'd65535;
	localparam logic [63:0] HALF_LSB  = 64'd1 << 17;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      saturated;
	} window_result_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data  = '0;
	logic                      in_valid  = 1'b0;
	logic                      in_ready;
	logic [SAMPLE_W-1:0]       sample    = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [VALUE_W-1:0] value;
	logic                      saturated;

	// Predictor copy of the registers and the open window
	logic [MODE_W-1:0] cur_mode;
	logic [CNT_W-1:0]  cur_len;
	logic [ZP_W-1:0]   cur_zero;
	logic [GAIN_W-1:0] cur_gain;
	logic [SUM_W-1:0]  acc_sum;
	logic [CNT_W-1:0]  acc_count;
	logic [ZP_W-1:0]   last_cal_mean;

	window_result_t expected_results[$];
	window_result_t oldest_result;

	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned burst_left     = 0;
	int unsigned stall_style    = 0;
	int unsigned stall_age      = 0;
	int unsigned stall_hold     = 0;

	current_sense_dc_rms_averager u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.saturated (saturated)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("current_sense_dc_rms_averager test failed");
			$finish;
		end
	end

	// Stall the result channel in one of three styles, picking a new style at random intervals
	always @(posedge clk) begin
		if (stall_age == 0) begin
			stall_style = $urandom_range(0, 2);
			stall_age   = $urandom_range(100, 600);
		end
		stall_age--;
		case (stall_style)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= 1'($urandom_range(0, 1));
			end
			default: begin
				if (stall_hold == 0) begin
					stall_hold = out_ready ? $urandom_range(1, 40) : $urandom_range(1, 6);
					out_ready <= !out_ready;
				end else begin
					stall_hold--;
				end
			end
		endcase
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%0d saturated=%0b",
					value, saturated));
			end else begin
				oldest_result = expected_results.pop_front();
				if (value !== oldest_result.value)
					report_mismatch($sformatf("value %0d, predicted %0d",
						value, oldest_result.value));
				if (saturated !== oldest_result.saturated)
					report_mismatch($sformatf("saturated %0b, predicted %0b",
						saturated, oldest_result.saturated));
			end
		end
	end

	function automatic logic [63:0] nearest_root(input logic [63:0] x);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int b = 25; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= x)
				root = trial;
		end
		// round up once x lies beyond (root + 1/2)^2
		if (x - root * root > root)
			root = root + 1;
		return root;
	endfunction

	function automatic logic [63:0] to_milliamps(input logic [63:0] q4);
		return (q4 * 64'(cur_gain) + HALF_LSB) >> 18;
	endfunction

	// Fold one sample into the window; queue a result when the window closes
	task automatic predict_window(input logic [SAMPLE_W-1:0] s);
		logic [63:0]    n;
		logic [63:0]    sq4;
		logic [63:0]    offset;
		logic [63:0]    mean;
		logic [63:0]    mag;
		window_result_t res;
		n = (cur_len == '0) ? 64'd1 : 64'(cur_len);
		if (cur_mode == MODE_RMS) begin
			sq4    = 64'(s) << 4;
			offset = (sq4 >= 64'(cur_zero)) ? sq4 - 64'(cur_zero) : 64'(cur_zero) - sq4;
			acc_sum = acc_sum + SUM_W'(offset * offset);
		end else begin
			acc_sum = acc_sum + SUM_W'(s);
		end
		acc_count = acc_count + 1'b1;
		if (acc_count == '0 || 64'(acc_count) >= n) begin
			res.saturated = 1'b0;
			if (cur_mode == MODE_RMS) begin
				mag = to_milliamps(nearest_root((64'(acc_sum) + n / 2) / n));
				if (mag > POS_LIMIT) begin
					mag = POS_LIMIT;
					res.saturated = 1'b1;
				end
				res.value = VALUE_W'(mag);
			end else begin
				mean = ((64'(acc_sum) << 4) + n / 2) / n;
				if (mean > MEAN_CLIP) begin
					mean = MEAN_CLIP;
					res.saturated = 1'b1;
				end
				if (cur_mode == MODE_CAL) begin
					res.value     = VALUE_W'(mean);
					last_cal_mean = ZP_W'(mean);
				end else if (mean >= 64'(cur_zero)) begin
					mag = to_milliamps(mean - 64'(cur_zero));
					if (mag > POS_LIMIT) begin
						mag = POS_LIMIT;
						res.saturated = 1'b1;
					end
					res.value = VALUE_W'(mag);
				end else begin
					mag = to_milliamps(64'(cur_zero) - mean);
					if (mag > NEG_LIMIT) begin
						mag = NEG_LIMIT;
						res.saturated = 1'b1;
					end
					res.value = VALUE_W'(64'd0 - mag);
				end
			end
			acc_sum   = '0;
			acc_count = '0;
			expected_results.push_back(res);
		end
	endtask

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_MODE:       cur_mode = data[MODE_W-1:0];
			REG_WINDOW_LEN: cur_len  = data[CNT_W-1:0];
			REG_ZERO_POINT: cur_zero = data[ZP_W-1:0];
			REG_GAIN:       cur_gain = data[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	// One register write beat; cfg_valid is dropped again before the task returns
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_settings(input logic [MODE_W-1:0] m, input logic [CNT_W-1:0] len,
		input logic [ZP_W-1:0] zp, input logic [GAIN_W-1:0] g);
		write_reg(REG_MODE, CFG_DATA_W'(m));
		write_reg(REG_WINDOW_LEN, CFG_DATA_W'(len));
		write_reg(REG_ZERO_POINT, CFG_DATA_W'(zp));
		write_reg(REG_GAIN, CFG_DATA_W'(g));
	endtask

	// Fill the bits above a register's width with noise
	function automatic logic [CFG_DATA_W-1:0] pad_noise(input logic [CFG_DATA_W-1:0] v,
		input int w);
		logic [CFG_DATA_W-1:0] keep;
		keep = (CFG_DATA_W'(1) << w) - 1'b1;
		return (CFG_DATA_W'($urandom) & ~keep) | (v & keep);
	endfunction

	// Hold off until every result is in and the block has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Send one sample beat, opening a new burst after a random gap when due
	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (!in_ready);
		predict_window(s);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int c;
		c = int'(cur_zero >> 4) + int'($urandom_range(0, 160)) - 80;
		if (c < 0)
			c = 0;
		if (c > int'(SAMPLE_MAX))
			c = int'(SAMPLE_MAX);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return SAMPLE_MAX;
			2, 3:    return SAMPLE_W'(c);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// One full window at the reset settings
	task automatic test_reset_defaults();
		repeat (int'(RST_WINDOW_LEN)) send_sample(pick_sample());
	endtask

	// Zero window length acts as one sample per window
	task automatic test_zero_window();
		settle();
		write_settings(MODE_DC, '0, '0, GAIN_MAX);
		send_sample('0);
		send_sample(SAMPLE_MAX);
		send_sample(12'hAAA);
		send_sample(12'h555);
	endtask

	// Negative and positive DC, the spare mode code, and zero gain
	task automatic test_dc_polarity();
		settle();
		write_settings(MODE_DC, CNT_W'(1), '0, GAIN_MAX);
		write_reg(REG_ZERO_POINT, '1);
		send_sample('0);
		settle();
		write_settings(MODE_DC_ALT, CNT_W'(1), '0, GAIN_MAX);
		send_sample(SAMPLE_MAX);
		settle();
		write_reg(REG_GAIN, '0);
		send_sample(12'h800);
	endtask

	task automatic test_calibrate();
		settle();
		write_settings(MODE_CAL, CNT_W'(2), RST_ZERO_POINT, RST_GAIN);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX - 1'b1);
	endtask

	task automatic test_rms_basic();
		settle();
		write_settings(MODE_RMS, CNT_W'(2), RST_ZERO_POINT, RST_GAIN);
		send_sample(SAMPLE_MAX);
		send_sample('0);
	endtask

	// Mode changes inside an open window, including a clipped mean
	task automatic test_mode_switch();
		settle();
		write_settings(MODE_DC, CNT_W'(4), RST_ZERO_POINT, RST_GAIN);
		send_sample(12'h123);
		send_sample(12'hFED);
		settle();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_RMS));
		write_reg(REG_NONE, '1);
		send_sample('0);
		send_sample(SAMPLE_MAX);
		settle();
		write_settings(MODE_RMS, CNT_W'(3), '0, RST_GAIN);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		settle();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_DC));
		send_sample(SAMPLE_MAX);
	endtask

	// Shorten a long RMS window below its count to drive the output into the clip
	task automatic test_rms_saturation();
		settle();
		write_settings(MODE_RMS, '1, '0, GAIN_MAX);
		repeat (8) send_sample(SAMPLE_MAX);
		settle();
		write_reg(REG_WINDOW_LEN, CFG_DATA_W'(1));
		send_sample(SAMPLE_MAX);
	endtask

	// Random settings, each followed by a few windows and often a partial one
	task automatic test_random_windows();
		logic [MODE_W-1:0] m;
		logic [CNT_W-1:0]  len;
		logic [ZP_W-1:0]   zp;
		logic [GAIN_W-1:0] g;
		int unsigned       n;
		int unsigned       count;
		int unsigned       sent;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			m = MODE_W'($urandom);
			case ($urandom_range(0, 19))
				0, 1:    len = '0;
				2, 3, 4: len = CNT_W'($urandom_range(13, 64));
				5:       len = CNT_W'($urandom_range(65, 160));
				default: len = CNT_W'($urandom_range(1, 12));
			endcase
			case ($urandom_range(0, 7))
				0:       zp = '0;
				1:       zp = '1;
				2, 3:    zp = last_cal_mean;
				default: zp = ZP_W'($urandom);
			endcase
			case ($urandom_range(0, 7))
				0:       g = '0;
				1:       g = GAIN_MAX;
				2:       g = RST_GAIN;
				default: g = GAIN_W'($urandom);
			endcase
			write_reg(REG_MODE, pad_noise(CFG_DATA_W'(m), MODE_W));
			write_reg(REG_WINDOW_LEN, pad_noise(CFG_DATA_W'(len), CNT_W));
			write_reg(REG_ZERO_POINT, pad_noise(CFG_DATA_W'(zp), ZP_W));
			write_reg(REG_GAIN, pad_noise(CFG_DATA_W'(g), GAIN_W));
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_IDX_W'($urandom_range(int'(REG_GAIN) + 1, 255)),
					CFG_DATA_W'($urandom));
			n = (len == '0) ? 1 : int'(len);
			count = n * ((n > 64) ? 1 : $urandom_range(1, 5));
			if ($urandom_range(0, 2) == 0)
				count += $urandom_range(0, n - 1);
			repeat (count) send_sample(pick_sample());
			sent += count;
		end
	endtask

	initial begin
		cur_mode      = RST_MODE;
		cur_len       = RST_WINDOW_LEN;
		cur_zero      = RST_ZERO_POINT;
		cur_gain      = RST_GAIN;
		acc_sum       = '0;
		acc_count     = '0;
		last_cal_mean = RST_ZERO_POINT;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_zero_window();
		test_dc_polarity();
		test_calibrate();
		test_rms_basic();
		test_mode_switch();
		test_rms_saturation();
		test_random_windows();

		settle();
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("current_sense_dc_rms_averager test passed");
		end else begin
			$display("current_sense_dc_rms_averager test failed");
		end
		$finish;
	end

endmodule
